// File: sv/gplp_pkg.sv
// package for the grid piecewise linear predictor
// holds sizes, operation codes and the request / response structs; no dependencies
package gplp_pkg;

   localparam int NumFeatures = 4;
   localparam int NumDividers = 3;
   localparam int CoefSlots   = NumFeatures + 1;
   localparam int Radix       = NumDividers + 1;
   localparam int NumCells    = (Radix ** NumFeatures >= 256) ? 256 : Radix ** NumFeatures;
   localparam int CoefDepth   = NumCells * CoefSlots;
   localparam int DivDepth    = NumFeatures * NumDividers;
   localparam int CoefAddrW   = $clog2(CoefDepth);
   localparam int DivAddrW    = (DivDepth > 1) ? $clog2(DivDepth) : 1;
   localparam int FeatW       = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;
   localparam int BucketW     = $clog2(NumDividers + 1);
   // each shifted product reaches 2^46; up to 4 of them plus the offset
   localparam int SumW        = 52;

   typedef enum logic [1:0] {
      OP_WRITE_DIVIDER = 2'd0,
      OP_WRITE_COEFF   = 2'd1,
      OP_FEED          = 2'd2,
      OP_UNUSED        = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         feature_index;
      logic [2:0]         divider_index;
      logic [7:0]         cell_index;
      logic [3:0]         coeff_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] prediction;
      logic [7:0]         cell_number;
      logic               cell_known;
      logic               saturated;
   } rsp_type;

   // controller commands to the datapath
   typedef struct packed {
      logic              capture;    // register incoming item
      logic              div_write;
      logic              coef_write;
      logic              feed;       // bucket compare and buffer write
      logic              clear_acc;
      logic              mac_read;   // read coefficient/feature at index
      logic              mac_add;    // accumulate product of previous read
      logic [3:0]        mac_index;
      logic              finish;     // saturate and present result
   } cmd_type;

   typedef struct packed {
      logic is_last;      // fed feature is the last one
      logic known;        // cell of the sample is known
      logic valid_write;  // write is in range
      logic valid_feed;
   } status_type;

endpackage

// File: sv/gplp_datapath.sv
// datapath: divider/coefficient stores, known map, feature buffer, mac unit
// depends on gplp_pkg
module gplp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gplp_pkg::req_type   req_in,
   input  gplp_pkg::cmd_type   cmd,
   output gplp_pkg::status_type status,
   output gplp_pkg::rsp_type   rsp_data
);

   gplp_pkg::req_type item_ff;
   logic signed [31:0] div_mem [gplp_pkg::DivDepth];
   logic signed [31:0] coef_mem [gplp_pkg::CoefDepth];
   logic [gplp_pkg::NumCells-1:0] known_ff;
   logic signed [31:0] feat_ff [gplp_pkg::NumFeatures];
   logic [7:0] cell_ff;
   logic signed [31:0] coef_rd_ff, feat_rd_ff;
   logic signed [63:0] prod_ff;
   logic signed [gplp_pkg::SumW-1:0] acc_ff;
   logic [gplp_pkg::BucketW-1:0] bucket;
   logic [7:0] cell_in;
   logic [gplp_pkg::FeatW-1:0] fidx;
   logic [gplp_pkg::CoefAddrW-1:0] caddr_wr, caddr_rd;
   logic signed [gplp_pkg::SumW-1:0] sum_fin;
   gplp_pkg::rsp_type rsp_ff;

   assign fidx = item_ff.feature_index[gplp_pkg::FeatW-1:0];

   always_comb begin
      bucket = gplp_pkg::BucketW'(gplp_pkg::NumDividers);
      for (int j = gplp_pkg::NumDividers - 1; j >= 0; j--) begin
         if (item_ff.value <
             div_mem[gplp_pkg::DivAddrW'(int'(fidx) * gplp_pkg::NumDividers + j)]) begin
            bucket = gplp_pkg::BucketW'(j);
         end
      end
      if (item_ff.feature_index == 3'd0) begin
         cell_in = 8'(bucket);
      end else begin
         cell_in = 8'(16'(cell_ff) * 16'(gplp_pkg::Radix) + 16'(bucket));
      end
   end

   assign status.valid_write = (item_ff.operation == gplp_pkg::OP_WRITE_DIVIDER) ?
      (32'(item_ff.feature_index) < 32'(gplp_pkg::NumFeatures) &&
       32'(item_ff.divider_index) < 32'(gplp_pkg::NumDividers)) :
      (32'(item_ff.coeff_index) <= 32'(gplp_pkg::NumFeatures) &&
       32'(item_ff.cell_index) < 32'(gplp_pkg::NumCells));
   assign status.valid_feed = 32'(item_ff.feature_index) < 32'(gplp_pkg::NumFeatures);
   assign status.is_last = 32'(item_ff.feature_index) == 32'(gplp_pkg::NumFeatures - 1);
   assign status.known = known_ff[cell_ff];

   assign caddr_wr = gplp_pkg::CoefAddrW'(32'(item_ff.cell_index) * gplp_pkg::CoefSlots
                                          + 32'(item_ff.coeff_index));
   assign caddr_rd = gplp_pkg::CoefAddrW'(32'(cell_ff) * gplp_pkg::CoefSlots
                                          + 32'(cmd.mac_index));

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_in;
      if (cmd.div_write)
         div_mem[gplp_pkg::DivAddrW'(32'(item_ff.feature_index) * gplp_pkg::NumDividers
                                     + 32'(item_ff.divider_index))] <= item_ff.value;
      if (cmd.coef_write) coef_mem[caddr_wr] <= item_ff.value;
      if (cmd.mac_read) begin
         coef_rd_ff <= coef_mem[caddr_rd];
         feat_rd_ff <= (32'(cmd.mac_index) < 32'(gplp_pkg::NumFeatures)) ?
                       feat_ff[gplp_pkg::FeatW'(cmd.mac_index)] : 32'sd65536;
      end
      if (cmd.feed) feat_ff[fidx] <= item_ff.value;
      prod_ff <= 64'(coef_rd_ff) * 64'(feat_rd_ff);
   end

   // offset slot multiplies by 1.0 so the floor shift returns it unchanged
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         cell_ff  <= '0;
         acc_ff   <= '0;
      end else begin
         if (cmd.coef_write) known_ff[item_ff.cell_index] <= 1'b1;
         if (cmd.feed) cell_ff <= cell_in;
         if (cmd.clear_acc) acc_ff <= '0;
         else if (cmd.mac_add) acc_ff <= acc_ff + gplp_pkg::SumW'(prod_ff >>> 16);
      end
   end

   always_comb begin
      sum_fin = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.cell_number <= cell_ff;
         rsp_ff.cell_known  <= status.known;
         if (!status.known) begin
            rsp_ff.prediction <= '0;
            rsp_ff.saturated  <= 1'b0;
         end else if (sum_fin > gplp_pkg::SumW'(64'sh7fffffff)) begin
            rsp_ff.prediction <= 32'sh7fffffff;
            rsp_ff.saturated  <= 1'b1;
         end else if (sum_fin < -gplp_pkg::SumW'(64'sh80000000)) begin
            rsp_ff.prediction <= 32'sh80000000;
            rsp_ff.saturated  <= 1'b1;
         end else begin
            rsp_ff.prediction <= sum_fin[31:0];
            rsp_ff.saturated  <= 1'b0;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/gplp_control.sv
// controller state machine sequencing writes, feeds and the multiply-accumulate
// depends on gplp_pkg
module gplp_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           operation,
   input  logic                 offset_enable,
   input  gplp_pkg::status_type status,
   output gplp_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_MAC, S_DRAIN1, S_DRAIN2, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] last_idx;
   logic rsp_valid_ff, rsp_valid_in;

   assign last_idx = offset_enable ? 4'(gplp_pkg::NumFeatures)
                                   : 4'(gplp_pkg::NumFeatures - 1);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      idx_in = idx_ff;
      rsp_valid_in = 1'b0;
      cmd.mac_index = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (gplp_pkg::op_type'(op_ff))
               gplp_pkg::OP_WRITE_DIVIDER: cmd.div_write = status.valid_write;
               gplp_pkg::OP_WRITE_COEFF:   cmd.coef_write = status.valid_write;
               gplp_pkg::OP_FEED: begin
                  cmd.feed = status.valid_feed;
                  if (status.valid_feed && status.is_last) begin
                     state_in = S_MAC;
                     idx_in = '0;
                     cmd.clear_acc = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_MAC: begin
            cmd.mac_read = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == last_idx) state_in = S_DRAIN1;
         end
         S_DRAIN1: state_in = S_DRAIN2;
         S_DRAIN2: state_in = S_FINISH;
         S_FINISH: begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         op_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         if (cmd.capture) op_ff <= operation;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/grid_piecewise_linear_predictor.sv
// top level of the grid piecewise linear predictor
// depends on gplp_pkg, gplp_control, gplp_datapath
//
// usage:
//   req_ : command channel; an item transfers when start is high and busy low
//   csr_ : write channel for offset_enable; transfers on csr_valid && csr_ready
//   rsp_ : one result per last-feature feed, shown for one cycle with rsp_valid
// sequence:
//   divider and coefficient writes go through a capture step and a store write
//   a feed goes through capture and a buffer write; the last feature adds a serial multiply-accumulate
//   over the cell's slots: one coefficient read per slot, a 2-stage product
//   pipe and a saturate step; the cell has 4 slots, or 5 when offset_enable is set
//   the single shared multiplier and coefficient memory port serialize the slots
// reset:
//   clears the controller, cell number, accumulator and the known map
//   (flip-flops), offset_enable goes to 0; stores stay undefined
// the receiver cannot stall: results are presented once and not held
module grid_piecewise_linear_predictor (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gplp_pkg::req_type  req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data,
   output logic               rsp_valid,
   output gplp_pkg::rsp_type  rsp_data
);

   gplp_pkg::cmd_type    cmd, cmd_ctl;
   gplp_pkg::status_type status;
   logic offset_enable_ff;
   logic [1:0] rd_pipe_ff;

   // config only while idle
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_enable_ff <= 1'b0;
         rd_pipe_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) offset_enable_ff <= csr_data;
         rd_pipe_ff <= {rd_pipe_ff[0], cmd_ctl.mac_read};
      end
   end

   gplp_control u_control (
      .clock, .reset, .start,
      .operation(req_data.operation),
      .offset_enable(offset_enable_ff),
      .status, .cmd(cmd_ctl), .busy, .rsp_valid
   );

   // accumulate when the product of a read has passed the read and product registers
   always_comb begin
      cmd = cmd_ctl;
      cmd.mac_add = rd_pipe_ff[1];
   end

   gplp_datapath u_datapath (
      .clock, .reset, .req_in(req_data),
      .cmd, .status, .rsp_data
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy == 1'b0) else $error("result while busy");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item not started");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");

endmodule
